// File: rtl/core/srr_pkg.sv
package srr_pkg;

   // Field widths of the items.
   localparam int unsigned SEQ_W   = 32;
   localparam int unsigned LEN_W   = 11;
   localparam int unsigned TOTAL_W = 24;
   localparam int unsigned WIN_W   = 6;

   // Window size after reset.
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

   // Saturation point of the byte total.
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Configuration register indexes.
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_INITIAL_SEQ = 1'b0;
   localparam csr_index_type CSR_WINDOW_SIZE = 1'b1;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_num;
      logic             check_ok;
      logic             is_end;
      logic [LEN_W-1:0] payload_len;
   } req_payload_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   ack_num;
      logic               send_end_ack;
      logic               store_payload;
      logic [SEQ_W-1:0]   store_slot;
      logic [TOTAL_W-1:0] total_bytes;
      logic [SEQ_W-1:0]   window_base;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type    reg_index;
      logic [SEQ_W-1:0] wdata;
   } csr_payload_type;

   // Controls that drive one mark cell.
   typedef struct packed {
      logic clear;
      logic set;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SLIDE
   } state_type;

endpackage

// File: rtl/core/srr_chan_if.sv
interface srr_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/srr_cell.sv
module srr_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  srr_pkg::cell_ctrl_type ctrl,
   input  logic                  upper_mark,
   output logic                  mark
);
   import srr_pkg::*;

   logic mark_ff;
   logic mark_in;

   // A clear wins over a set, and a set over the shift; set and shift never come in the same cycle.
   always_comb begin
      mark_in = mark_ff;
      if (ctrl.clear) begin
         mark_in = 1'b0;
      end else if (ctrl.set) begin
         mark_in = 1'b1;
      end else if (ctrl.shift) begin
         mark_in = upper_mark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   assign mark = mark_ff;

endmodule

// File: rtl/core/selective_repeat_receiver_unit.sv
// Receiver side of a selective-repeat ARQ link, header path only. Each request
// item is one packet header; each produces exactly one response item with the
// acknowledgement, the payload store command, the running byte total and the
// window base. Marks for received packets live in a row of cells indexed by
// distance from the base, so cell k holds the mark of sequence number base + k.
// A header that does not land on the base is accepted and its response is
// loaded into the output register on the same clock edge. A new header that
// lands on the base starts a slide: the cell row shifts down by one cell per
// cycle while the bottom cell is marked, advancing the base past the run of
// consecutively received numbers (1 to WINDOW_SLOTS of them); the response is
// loaded once the bottom cell is clear. One item is in
// work at a time; the next request is taken once the output register is free
// or being emptied. Configuration writes are always accepted and must only be
// issued while the block is idle; writing initial_seq starts a new transfer
// and clears all marks and the byte total at once, with no clearing pass.
module selective_repeat_receiver_unit #(
   parameter int unsigned WINDOW_SLOTS = 32,
   parameter int unsigned MAX_PAYLOAD  = 1024
) (
   input logic clock,
   input logic reset,
   srr_chan_if.sink   req_ch,
   srr_chan_if.source rsp_ch,
   srr_chan_if.sink   csr_ch
);
   import srr_pkg::*;

   localparam int unsigned IDX_W = $clog2(WINDOW_SLOTS);

   // Transfer state.
   logic [SEQ_W-1:0]   base_ff, base_in;
   logic [SEQ_W-1:0]   last_ack_ff, last_ack_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [WIN_W-1:0]   window_ff, window_in;
   state_type          state_ff, state_in;

   // Sequence number of the header that started a slide.
   logic [SEQ_W-1:0] pend_seq_ff, pend_seq_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Cell row.
   logic [WINDOW_SLOTS-1:0] mark_vec;
   logic                    mark_set;
   logic                    mark_shift;
   logic                    mark_clear;

   // Header decode.
   req_payload_type  hdr;
   logic             req_acc;
   logic             csr_acc;
   logic             rsp_free;
   logic [SEQ_W-1:0] seq_dist;
   logic [SEQ_W-1:0] eff_win;
   logic [SEQ_W-1:0] win32;
   logic             in_win;
   logic             behind;
   logic [IDX_W-1:0] dist_idx;
   logic             is_new;
   logic [15:0]      len_clip;
   logic [TOTAL_W:0] sum;
   logic [TOTAL_W-1:0] total_sat;

   assign hdr      = req_ch.data;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_acc  = req_ch.valid && req_ch.ready;
   assign csr_acc  = csr_ch.valid && csr_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE) && rsp_free;
   assign csr_ch.ready = 1'b1;

   // A zero window acts as one; a window wider than the cell row is clipped to it.
   assign win32 = SEQ_W'(window_ff);
   always_comb begin
      if (window_ff == '0) begin
         eff_win = SEQ_W'(1);
      end else if (win32 > SEQ_W'(WINDOW_SLOTS)) begin
         eff_win = SEQ_W'(WINDOW_SLOTS);
      end else begin
         eff_win = win32;
      end
   end

   // Distance from the base is taken modulo 2^32; the upper half counts as behind.
   assign seq_dist = hdr.seq_num - base_ff;
   assign in_win   = seq_dist < eff_win;
   assign behind   = seq_dist[SEQ_W-1];
   assign dist_idx = seq_dist[IDX_W-1:0];
   assign is_new   = !mark_vec[dist_idx];

   // Oversize payloads count as the largest allowed; the total saturates.
   assign len_clip  = (17'(hdr.payload_len) > 17'(MAX_PAYLOAD)) ?
                      16'(MAX_PAYLOAD) : 16'(hdr.payload_len);
   assign sum       = (TOTAL_W+1)'(total_ff) + (TOTAL_W+1)'(len_clip);
   assign total_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

   always_comb begin
      base_in      = base_ff;
      last_ack_in  = last_ack_ff;
      total_in     = total_ff;
      window_in    = window_ff;
      state_in     = state_ff;
      pend_seq_in  = pend_seq_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mark_set     = 1'b0;
      mark_shift   = 1'b0;
      mark_clear   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               // Default reply: repeat the last acknowledgement, store nothing.
               rsp_valid_in              = 1'b1;
               rsp_data_in.ack_num       = last_ack_ff;
               rsp_data_in.send_end_ack  = 1'b0;
               rsp_data_in.store_payload = 1'b0;
               rsp_data_in.store_slot    = '0;
               rsp_data_in.total_bytes   = total_ff;
               rsp_data_in.window_base   = base_ff;
               if (hdr.check_ok && hdr.is_end) begin
                  rsp_data_in.ack_num      = hdr.seq_num;
                  rsp_data_in.send_end_ack = 1'b1;
               end else if (hdr.check_ok && in_win) begin
                  rsp_data_in.ack_num = hdr.seq_num;
                  last_ack_in         = hdr.seq_num;
                  if (is_new) begin
                     mark_set                  = 1'b1;
                     total_in                  = total_sat;
                     rsp_data_in.store_payload = 1'b1;
                     rsp_data_in.store_slot    = hdr.seq_num;
                     rsp_data_in.total_bytes   = total_sat;
                     if (seq_dist == '0) begin
                        // The base arrived: hold the reply until the slide ends.
                        rsp_valid_in = 1'b0;
                        pend_seq_in  = hdr.seq_num;
                        state_in     = ST_SLIDE;
                     end
                  end
               end else if (hdr.check_ok && behind) begin
                  rsp_data_in.ack_num = hdr.seq_num;
                  last_ack_in         = hdr.seq_num;
               end
            end
         end
         ST_SLIDE: begin
            if (mark_vec[0]) begin
               mark_shift = 1'b1;
               base_in    = base_ff + SEQ_W'(1);
            end else begin
               // The output register was emptied when this item was taken.
               rsp_valid_in              = 1'b1;
               rsp_data_in.ack_num       = pend_seq_ff;
               rsp_data_in.send_end_ack  = 1'b0;
               rsp_data_in.store_payload = 1'b1;
               rsp_data_in.store_slot    = pend_seq_ff;
               rsp_data_in.total_bytes   = total_ff;
               rsp_data_in.window_base   = base_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_acc) begin
         case (csr_ch.data.reg_index)
            CSR_INITIAL_SEQ: begin
               base_in     = csr_ch.data.wdata;
               last_ack_in = csr_ch.data.wdata;
               total_in    = '0;
               mark_clear  = 1'b1;
            end
            CSR_WINDOW_SIZE: begin
               window_in = csr_ch.data.wdata[WIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         last_ack_ff  <= '0;
         total_ff     <= '0;
         window_ff    <= WINDOW_RESET;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         last_ack_ff  <= last_ack_in;
         total_ff     <= total_in;
         window_ff    <= window_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_seq_ff <= pend_seq_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Row of mark cells; each takes its upper neighbor's mark when the base moves.
   for (genvar k = 0; k < WINDOW_SLOTS; k++) begin : g_cell
      cell_ctrl_type ctrl;
      logic          upper;

      assign ctrl.clear = mark_clear;
      assign ctrl.set   = mark_set && (dist_idx == IDX_W'(k));
      assign ctrl.shift = mark_shift;

      if (k == WINDOW_SLOTS - 1) begin : g_top
         assign upper = 1'b0;
      end else begin : g_mid
         assign upper = mark_vec[k+1];
      end

      srr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .upper_mark (upper),
         .mark       (mark_vec[k])
      );
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

// File: rtl/core/srr_checker.sv
module srr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input srr_pkg::rsp_payload_type rsp_data
);
   import srr_pkg::*;

   // A waiting result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // No new item is taken while a result waits.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("request taken while response stalled");

   // An end acknowledgement never asks for a payload write.
   a_end_no_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_end_ack |-> !rsp_data.store_payload)
      else $error("end acknowledgement with store");

   // Without a store the slot reads zero.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.store_payload |-> rsp_data.store_slot == '0)
      else $error("slot set without store");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind selective_repeat_receiver_unit srr_checker u_srr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
